>>> src/ttwg_pkg.sv
// Package with types, constants and helper functions for the tone wave generator.
package ttwg_pkg;

  // Table length and phase table depth, both powers of two.
  localparam int TABLE_STEPS    = 16;
  localparam int SINE_LUT_DEPTH = 256;

  typedef enum logic [1:0] {
    MODE_BOOT  = 2'd0,
    MODE_THERM = 2'd1,
    MODE_TABLE = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_CAL_LOW  = 3'd0,
    CFG_CAL_HIGH = 3'd1,
    CFG_REF_CAL  = 3'd2,
    CFG_TONE_LOW = 3'd3,
    CFG_TONE_HIGH = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_SPK,
    ST_RCP1,
    ST_RCP2,
    ST_RCP3,
    ST_TONE,
    ST_OUT
  } state_t;

  // Divider request/status between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  localparam logic [31:0] RESET_STEP = 32'd214748365;
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;

  // Truncating Q30 product on magnitudes with sign.
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  pt;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    p  = ua * ub;
    pt = p[93:30];
    qmul = (a[63] != b[63]) ? -$signed(pt) : $signed(pt);
  endfunction

  // Sine code for point k of a circle of n = 2^lg points.
  function automatic logic [11:0] sine_code(input logic [31:0] k, input int lg);
    logic [33:0]        k4;
    logic [1:0]         q;
    logic [33:0]        r;
    logic signed [63:0] f;
    logic signed [63:0] g;
    logic signed [63:0] g2;
    logic signed [63:0] s;
    logic signed [63:0] y;
    logic [63:0]        tot;
    logic [75:0]        prod;
    k4 = {k, 2'b00};
    q  = 2'(k4 >> lg);
    r  = k4 & ((34'd1 << lg) - 34'd1);
    f  = $signed(64'({r, 30'd0} >> lg));
    g  = q[0] ? $signed(Q30_ONE) - f : f;
    if (g >= $signed(Q30_ONE)) begin
      y = $signed(Q30_ONE);
    end else if (g <= 0) begin
      y = 0;
    end else begin
      g2 = qmul(g, g);
      s = 64'sd172272;
      s = -64'sd5026995 + qmul(s, g2);
      s = 64'sd85569306 + qmul(s, g2);
      s = -64'sd693598671 + qmul(s, g2);
      s = 64'sd1686629713 + qmul(s, g2);
      y = qmul(s, g);
      if (y > $signed(Q30_ONE)) y = $signed(Q30_ONE);
      if (y < 0) y = 0;
    end
    if (q[1]) y = -y;
    tot  = 64'($signed(Q30_ONE) + y);
    prod = 76'(tot) * 76'd4095;
    sine_code = prod[42:31];
  endfunction

endpackage

>>> src/ttwg_div.sv
// Restoring divider, one quotient bit per cycle.
module ttwg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ttwg_pkg::div_req_t req,
  output ttwg_pkg::div_rsp_t rsp
);
  import ttwg_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  // One shift and subtract per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> src/temperature_tone_wave_generator_top.sv
// Top level: tick sequencer, state registers and result register.
// An input transaction passes ST_DIV, ST_SPK and ST_OUT in init or fixed mode, plus
// ST_RCP1 to ST_RCP3 and ST_TONE in temperature mode; a sensor update adds the
// temperature division in the 64-step divider (ST_STEP). One transaction at a
// time: in_tready is low from acceptance until the result is taken. Reset (rst_n,
// synchronous, active low) sets all registers but spk_r, tone_r, sval_r, mul_r, rcp_r.
module temperature_tone_wave_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: button_level[0], ref_reading[12:1], ref_valid[13],
  // sensor_reading[25:14], sensor_valid[26]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: speaker_code[11:0], tone_code[23:12], led_on[24]
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import ttwg_pkg::*;

  localparam int TW  = $clog2(TABLE_STEPS);
  localparam int SLG = $clog2(SINE_LUT_DEPTH);
  localparam int HALF = TABLE_STEPS / 2;
  localparam logic [11:0] SAW_INC = 12'(4095 / TABLE_STEPS);
  localparam logic [11:0] TRI_INC = 12'(4095 / HALF);
  // Reciprocals of 625 for a 21-bit and a 30-bit dividend.
  localparam logic [42:0] RCP_M1 = 43'd3435974;
  localparam logic [60:0] RCP_M2 = 61'd1759218605;

  logic [11:0] cal_lo_r, cal_hi_r, ref_cal_r;
  logic [8:0]  tone_lo_r, tone_hi_r;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  wave_r, wave_nxt;
  logic        prev_btn_r, prev_btn_nxt;
  logic [TW-1:0] tidx_r, tidx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] step_r, step_nxt;
  logic [11:0] lref_r, lref_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  state_t      st_r, st_nxt;
  logic [11:0] spk_r, spk_nxt;
  logic [11:0] tone_r, tone_nxt;
  logic        ovld_r, ovld_nxt;
  logic        sens_r, sens_nxt;
  logic [11:0] sval_r, sval_nxt;
  logic        neg_r, neg_nxt;
  logic signed [63:0] mul_r, mul_nxt;
  logic [11:0] rcp_r, rcp_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  ttwg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Input field slices.
  logic        btn;
  logic [11:0] rref, rsens;
  logic        rok, sok;
  assign btn   = in_tdata[0];
  assign rref  = in_tdata[12:1];
  assign rok   = in_tdata[13];
  assign rsens = in_tdata[25:14];
  assign sok   = in_tdata[26];

  // Constant sine tables for the phase and for the fixed sine wave.
  logic [11:0] sine_lut [SINE_LUT_DEPTH];
  logic [11:0] tbl_sine [TABLE_STEPS];

  for (genvar gi = 0; gi < SINE_LUT_DEPTH; gi++) begin : g_sine_lut
    assign sine_lut[gi] = sine_code(32'(gi), SLG);
  end

  for (genvar gj = 0; gj < TABLE_STEPS; gj++) begin : g_tbl_sine
    assign tbl_sine[gj] = sine_code(32'(gj), TW);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r  <= 12'd1034;
      cal_hi_r  <= 12'd1370;
      ref_cal_r <= 12'd1655;
      tone_lo_r <= 9'd200;
      tone_hi_r <= 9'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_LOW:   cal_lo_r  <= cfg_data;
        CFG_CAL_HIGH:  cal_hi_r  <= cfg_data;
        CFG_REF_CAL:   ref_cal_r <= cfg_data;
        CFG_TONE_LOW:  tone_lo_r <= cfg_data[8:0];
        CFG_TONE_HIGH: tone_hi_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Table value for the fixed and init modes.
  function automatic logic [11:0] table_val(input logic [1:0] sel, input logic [TW-1:0] j,
                                            input logic [11:0] sv);
    logic [11:0] jj;
    jj = 12'(j);
    if (sel == 2'd1) begin
      if (32'(j) < HALF) table_val = 12'(jj * TRI_INC);
      else table_val = 12'd4095 - 12'((jj - 12'(HALF)) * TRI_INC);
    end else if (sel == 2'd2) begin
      table_val = sv;
    end else begin
      table_val = 12'(jj * SAW_INC);
    end
  endfunction

  // Temperature terms, computed from registered state.
  logic signed [31:0] span;
  logic signed [63:0] num_t, den_t, n2;
  logic signed [63:0] quo_s, tq;
  logic signed [31:0] tcl;
  logic signed [31:0] fhz;
  logic [31:0] acc2;
  logic [SLG-1:0] kacc, kacc2;
  logic [42:0] pa;
  logic [29:0] nb;
  logic [60:0] pq;

  always_comb begin
    span  = 32'($signed({1'b0, cal_hi_r})) - 32'($signed({1'b0, cal_lo_r}));
    num_t = mul_r;
    den_t = 64'(span) * 64'($signed({1'b0, lref_r}));
    n2    = 64'sd2 * num_t + den_t;
    quo_s = neg_r ? -$signed(drsp.quo) : $signed(drsp.quo);
    tq    = quo_s + 64'sd480;
    tcl   = (temp_r < -16'sd640) ? -32'sd640 :
            (temp_r > 16'sd1920) ? 32'sd1920 : 32'(temp_r);
    fhz   = 32'($signed({1'b0, tone_lo_r})) * 32'sd2560 +
            (tcl + 32'sd640) * (32'($signed({1'b0, tone_hi_r})) -
                                32'($signed({1'b0, tone_lo_r})));
    // Step = floor((F * 2^20 + 312) / 625) split as F = 625 * a + b.
    pa    = 43'(mul_r[20:0]) * RCP_M1;
    nb    = {mul_r[9:0], 20'd0} + 30'd312;
    pq    = 61'(nb) * RCP_M2;
    acc2  = acc_r + step_r;
    kacc  = acc_r[31 -: SLG];
    kacc2 = acc2[31 -: SLG];
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; wave_nxt = wave_r; prev_btn_nxt = prev_btn_r;
    tidx_nxt = tidx_r; acc_nxt = acc_r; step_nxt = step_r; lref_nxt = lref_r;
    temp_nxt = temp_r; spk_nxt = spk_r; tone_nxt = tone_r; ovld_nxt = ovld_r;
    sens_nxt = sens_r; sval_nxt = sval_r; neg_nxt = neg_r; mul_nxt = mul_r;
    rcp_nxt = rcp_r;
    dreq = '0;
    in_tready = (st_r == ST_IDLE) && !ovld_r;
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          tone_nxt = sine_lut[kacc];
          acc_nxt  = acc_r + step_r;
          if (prev_btn_r && !btn) begin
            if (mode_r == MODE_BOOT) begin
              mode_nxt = MODE_THERM;
            end else begin
              mode_nxt = MODE_TABLE;
              case (wave_r)
                2'd0: wave_nxt = 2'd1;
                2'd1: wave_nxt = 2'd2;
                2'd2: wave_nxt = 2'd0;
                default: wave_nxt = 2'd1;
              endcase
            end
          end
          prev_btn_nxt = btn;
          if (rok && rref != 12'd0) lref_nxt = rref;
          sens_nxt = sok && (cal_hi_r > cal_lo_r);
          sval_nxt = rsens;
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Prepare the numerator product on a sensor update, then launch the temperature division; else go to ST_SPK.
        if (sens_r) begin
          mul_nxt = 64'sd1600 * (64'($signed({1'b0, sval_r})) *
                    64'($signed({1'b0, ref_cal_r})) -
                    64'($signed({1'b0, cal_lo_r})) * 64'($signed({1'b0, lref_r})));
          sens_nxt = 1'b0;
          neg_nxt  = 1'b1;
        end else if (neg_r) begin
          // floor division: negative numerators use ceil of magnitude
          neg_nxt = n2 < 0;
          dreq.start = 1'b1;
          dreq.num = (n2 < 0) ? 64'(-n2 + 2 * den_t - 64'sd1) : 64'(n2);
          dreq.den = 64'(2 * den_t);
          mul_nxt  = 64'sd1;
          st_nxt   = ST_STEP;
        end else begin
          st_nxt = ST_SPK;
        end
      end
      ST_STEP: begin
        if (mul_r == 64'sd1) begin
          mul_nxt = 64'sd0;
        end else if (drsp.done) begin
          if (tq > 64'sd32767) temp_nxt = 16'sh7fff;
          else if (tq < -64'sd32768) temp_nxt = -16'sh8000;
          else temp_nxt = 16'(tq);
          neg_nxt = 1'b0;
          st_nxt  = ST_SPK;
        end
      end
      ST_SPK: begin
        if (mode_r == MODE_THERM) begin
          mul_nxt = 64'(fhz);
          st_nxt  = ST_RCP1;
        end else begin
          spk_nxt = table_val((mode_r == MODE_TABLE) ? wave_r : 2'd0, tidx_r,
                              tbl_sine[tidx_r]);
          st_nxt  = ST_OUT;
        end
      end
      // Quotient of the tone frequency by 625.
      ST_RCP1: begin
        rcp_nxt = pa[42:31];
        st_nxt  = ST_RCP2;
      end
      // Remainder of the tone frequency by 625.
      ST_RCP2: begin
        mul_nxt = 64'(mul_r[20:0] - 21'(rcp_r) * 21'd625);
        st_nxt  = ST_RCP3;
      end
      // The remainder part stays below 2^20, so the two parts just join.
      ST_RCP3: begin
        step_nxt = {rcp_r, pq[59:40]};
        st_nxt   = ST_TONE;
      end
      ST_TONE: begin
        acc_nxt = acc2;
        spk_nxt = sine_lut[kacc2];
        st_nxt  = ST_OUT;
      end
      ST_OUT: begin
        tidx_nxt = tidx_r + TW'(1);
        ovld_nxt = 1'b1;
        st_nxt   = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mode_r <= MODE_BOOT; wave_r <= '0; prev_btn_r <= 1'b1;
      tidx_r <= '0; acc_r <= '0; step_r <= RESET_STEP; lref_r <= 12'd1655;
      temp_r <= '0; ovld_r <= 1'b0; sens_r <= 1'b0; neg_r <= 1'b0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; wave_r <= wave_nxt; prev_btn_r <= prev_btn_nxt;
      tidx_r <= tidx_nxt; acc_r <= acc_nxt; step_r <= step_nxt; lref_r <= lref_nxt;
      temp_r <= temp_nxt; ovld_r <= ovld_nxt; sens_r <= sens_nxt; neg_r <= neg_nxt;
    end
    spk_r  <= spk_nxt;
    tone_r <= tone_nxt;
    sval_r <= sval_nxt;
    mul_r  <= mul_nxt;
    rcp_r  <= rcp_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {7'd0, (mode_r == MODE_THERM), tone_r, spk_r};

endmodule

>>> src/ttwg_checker.sv
// Port-level checker for the tone wave generator, bound to the top level.
module ttwg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  // A transaction makes the block busy right away.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
  // No input is taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready with result pending");
  // A waiting result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tdata[31:25] == 7'd0) else $error("pad bits set");
endmodule

bind temperature_tone_wave_generator_top ttwg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
